// ===== hdl/grs_pkg.sv =====
`default_nettype none

package grs_pkg;

    // default store depth and register reset value
    localparam int unsigned MAX_GROUP_DEF = 16;
    localparam int unsigned GS_W          = 5;
    localparam logic [GS_W-1:0] GS_RESET  = 5'd2;

    typedef struct packed {
        logic signed [31:0] data_value;
        logic               list_end;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic               run_last;
        logic               out_list_end;
    } out_item_t;

    // tag that travels with one read of the group store
    typedef struct packed {
        logic valid;
        logic run_last;
        logic out_list_end;
    } rd_tag_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } ctrl_state_t;

endpackage

`default_nettype wire

// ===== hdl/grs_ram.sv =====
`default_nettype none

module grs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/grs_ctrl.sv =====
`default_nettype none

module grs_ctrl
    import grs_pkg::*;
#(
    parameter int unsigned MAX_GROUP = MAX_GROUP_DEF,
    localparam int unsigned ADDR_W = $clog2(MAX_GROUP),
    localparam int unsigned CNT_W  = $clog2(MAX_GROUP + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [GS_W-1:0]   cfg_data,
    input  wire logic              space,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [31:0]            ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr,
    output rd_tag_t                issue
);

    localparam int unsigned CMP_W = (CNT_W > GS_W) ? CNT_W : GS_W;

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              rev_reg, rev_next;
    logic              end_reg, end_next;
    logic [GS_W-1:0]   gs_reg, gs_next;

    logic [CMP_W-1:0]  gs_ext;
    logic [CMP_W-1:0]  k_eff;
    logic [CMP_W-1:0]  n_ext;
    logic              accept;
    logic              do_rev;
    logic              do_emit;
    logic              last_rd;

    // group size decode and emit decision for the incoming item
    always_comb
    begin
        accept  = in_valid && in_ready;
        gs_ext  = CMP_W'(gs_reg);
        k_eff   = (gs_ext > CMP_W'(MAX_GROUP)) ? CMP_W'(MAX_GROUP) : gs_ext;
        n_ext   = CMP_W'(fill_reg) + CMP_W'(1);
        do_rev  = (k_eff >= CMP_W'(2)) && (n_ext >= k_eff);
        do_emit = do_rev || (k_eff <= CMP_W'(1)) || in_data.list_end;
        last_rd = (remain_reg == CNT_W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && do_emit)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (space && last_rd)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath registers
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        cfg_ready   = 1'b1;
        ram_we      = accept;
        ram_waddr   = fill_reg[ADDR_W-1:0];
        ram_wdata   = in_data.data_value;
        ram_re      = 1'b0;
        ram_raddr   = addr_reg;
        issue       = '0;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        addr_next   = addr_reg;
        rev_next    = rev_reg;
        end_next    = end_reg;
        gs_next     = (cfg_valid && cfg_ready) ? cfg_data : gs_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (do_emit)
                    begin
                        fill_next   = '0;
                        remain_next = fill_reg + CNT_W'(1);
                        addr_next   = do_rev ? fill_reg[ADDR_W-1:0] : '0;
                        rev_next    = do_rev;
                        end_next    = in_data.list_end;
                    end
                    else
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (space)
                begin
                    ram_re             = 1'b1;
                    issue.valid        = 1'b1;
                    issue.run_last     = last_rd;
                    issue.out_list_end = last_rd && end_reg;
                    remain_next        = remain_reg - CNT_W'(1);
                    addr_next          = rev_reg ? addr_reg - ADDR_W'(1)
                                                 : addr_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            remain_reg <= '0;
            gs_reg     <= GS_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            gs_reg     <= gs_next;
        end
    end

    // read sequencing payload
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        rev_reg  <= rev_next;
        end_reg  <= end_next;
    end

endmodule

`default_nettype wire

// ===== hdl/grs_outbuf.sv =====
`default_nettype none

module grs_outbuf
    import grs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire rd_tag_t     issue,
    input  wire logic [31:0] rdata,
    output logic             space,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data
);

    rd_tag_t   pend_reg;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_reg, out_next;
    out_item_t skid_reg, skid_next;
    out_item_t arrive;
    logic      pop;
    logic [1:0] occ;

    // room check covers both entries and the read in flight
    always_comb
    begin
        pop    = out_valid_reg && out_ready;
        occ    = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, pend_reg.valid};
        space  = pop ? (occ <= 2'd2) : (occ <= 2'd1);
        arrive = '{out_value: rdata, run_last: pend_reg.run_last,
                   out_list_end: pend_reg.out_list_end};
    end

    // two-entry queue: output register plus skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        priority if (pop && pend_reg.valid)
        begin
            if (skid_valid_reg)
            begin
                out_next  = skid_reg;
                skid_next = arrive;
            end
            else
            begin
                out_next = arrive;
            end
        end
        else if (pop)
        begin
            out_next        = skid_reg;
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        else if (pend_reg.valid)
        begin
            if (!out_valid_reg)
            begin
                out_next       = arrive;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = arrive;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg       <= issue;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== hdl/group_reversal_stream.sv =====
// group_reversal_stream: reverses a stream of 32-bit values in groups.
// Input channel in_valid/in_ready/in_data carries one value and a list_end
// flag per transfer. Output channel out_valid/out_ready/out_data carries one
// reordered value per transfer, with run_last on the last result of an input
// and out_list_end on the last result of a list. cfg_valid/cfg_ready/cfg_data
// writes the group size (0 or 1 passes values through, above MAX_GROUP acts
// as MAX_GROUP); it is always ready and is to be written only while the
// block idles, which the block itself does not enforce. An input that
// completes a group of n values holds off input until all n are read, since
// the single read port of the group store gives out one value per cycle
// while the output queue has room; other inputs leave it ready for the next.
// A two-entry output queue keeps reads going at one per cycle while the
// receiver takes data; when the receiver stalls, reads pause and the
// current result holds steady. Reset empties the store, drops results not
// yet taken and sets the group size to 2. The store needs no clearing pass.
`default_nettype none

module group_reversal_stream
    import grs_pkg::*;
#(
    parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire in_item_t        in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output out_item_t            out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [GS_W-1:0] cfg_data
);

    localparam int unsigned ADDR_W = $clog2(MAX_GROUP);

    logic              space;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    rd_tag_t           issue;

    // sequencer: fill count, group size, read order
    grs_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .space     (space),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .issue     (issue)
    );

    // group store
    grs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_GROUP)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output queue
    grs_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .rdata     (ram_rdata),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/grs_checker.sv =====
`default_nettype none

module grs_checker
    import grs_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire in_item_t        in_data,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire out_item_t       out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // list end is only flagged on the last result of an input
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_list_end |-> out_data.run_last)
        else $error("list end without run last");

    // a list end always starts a drain, so input is held off
    a_end_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.list_end |=> !in_ready)
        else $error("input taken right after list end");

    // no result in the first cycle after reset
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind group_reversal_stream grs_checker u_grs_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import grs_pkg::*;

    localparam int unsigned MAX_GROUP    = MAX_GROUP_DEF;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    in_item_t        in_data;
    logic            out_valid;
    logic            out_ready;
    out_item_t       out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [GS_W-1:0] cfg_data;

    // model of the block: group size, stacked values and their count
    logic [GS_W-1:0]    size_reg_model;
    logic signed [31:0] group_buf [MAX_GROUP];
    int unsigned        group_fill;

    out_item_t   pending_results [$];
    int unsigned items_sent;
    int unsigned errors = 0;
    int unsigned stall_cycles = 0;
    bit          idle_en;
    int unsigned hold_requests = 0;

    group_reversal_stream #(
        .MAX_GROUP (MAX_GROUP_DEF)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // push one value and queue the values it releases
    task automatic predict_reorder(input in_item_t item);
        int unsigned k;
        int unsigned n;
        int unsigned i;
        int unsigned src;
        bit          rev;
        out_item_t   res;
        k = (size_reg_model > MAX_GROUP) ? MAX_GROUP : size_reg_model;
        if (group_fill < MAX_GROUP)
        begin
            group_buf[group_fill] = item.data_value;
            group_fill++;
        end
        n = group_fill;
        if (k >= 2 && n >= k)
            rev = 1'b1;
        else if (k <= 1 || item.list_end)
            rev = 1'b0;
        else
            return;
        for (i = 0; i < n; i++)
        begin
            src = rev ? (n - 1 - i) : i;
            res.out_value    = group_buf[src];
            res.run_last     = (i + 1 == n);
            res.out_list_end = (i + 1 == n) && item.list_end;
            pending_results.push_back(res);
        end
        group_fill = 0;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [GS_W-1:0] rand_size();
        case ($urandom_range(9))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return GS_W'($urandom_range(31, 17));
            default: return GS_W'($urandom_range(8, 2));
        endcase
    endfunction

    function automatic int unsigned rand_list_len();
        case ($urandom_range(3))
            0: return $urandom_range(4, 1);
            1: return $urandom_range(20, 5);
            2: return $urandom_range(48, 20);
            default: return $urandom_range(16, 1);
        endcase
    endfunction

    // offer one item and hold it until the transfer
    task automatic send_item(input logic signed [31:0] value, input logic last);
        in_item_t item;
        item.data_value = value;
        item.list_end   = last;
        while (idle_en && ($urandom_range(99) < 19))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_reorder(item);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_list(input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
            send_item(rand_value(), i + 1 == len);
    endtask

    // write the group size once the block has gone quiet
    task automatic set_group_size(input logic [GS_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        size_reg_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // reset value of 2: one pair reversed, then a lone value closing the list
    task automatic test_default_size();
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item('0, 1'b1);
    endtask

    // sizes 0 and 1 pass values straight through
    task automatic test_pass_through();
        set_group_size(5'd0);
        send_item(-32'sd1, 1'b0);
        set_group_size(5'd1);
        send_item(32'sd1, 1'b1);
    endtask

    // largest group, its last value also ending the list
    task automatic test_full_group_max();
        int unsigned i;
        set_group_size(5'd16);
        for (i = 0; i < 16; i++)
            send_item((i % 2) ? VAL_MAX : VAL_MIN + i, i == 15);
    endtask

    // size lowered below the stored count gives one longer reversed group
    task automatic test_size_lowered();
        set_group_size(5'd6);
        send_item(32'sd10, 1'b0);
        send_item(32'sd11, 1'b0);
        set_group_size(5'd2);
        send_item(32'sd12, 1'b0);
    endtask

    // stored values come out oldest first ahead of the new one
    task automatic test_switch_to_pass_through();
        set_group_size(5'd5);
        send_item(32'sd20, 1'b0);
        set_group_size(5'd0);
        send_item(32'sd21, 1'b1);
    endtask

    task automatic test_random_lists(input int unsigned target);
        int unsigned nlists;
        int unsigned j;
        while (items_sent < target)
        begin
            set_group_size(rand_size());
            nlists = $urandom_range(4, 1);
            for (j = 0; j < nlists; j++)
                send_list(rand_list_len());
        end
    endtask

    // neither side inserts random idle cycles
    task automatic test_no_idle_stretch();
        idle_en = 1'b0;
        set_group_size(GS_W'($urandom_range(8, 2)));
        send_list(30);
        send_list(30);
        idle_en = 1'b1;
    endtask

    // receiver stops for a long while so the block fills and stalls its input
    task automatic test_output_backpressure();
        set_group_size(5'd31);
        hold_requests++;
        send_list(40);
    endtask

    // receiver with random stalls and one long hold-off on request
    initial
    begin : receiver
        int unsigned n;
        int unsigned holds_done;
        holds_done = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                out_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            out_ready <= !(idle_en && ($urandom_range(99) < 19));
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        out_item_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: out_value %0d", out_data.out_value);
                errors++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (out_data.out_value !== head.out_value)
                begin
                    $error("out_value: expected %0d, actual %0d",
                           head.out_value, out_data.out_value);
                    errors++;
                end
                if (out_data.run_last !== head.run_last)
                begin
                    $error("run_last: expected %0b, actual %0b",
                           head.run_last, out_data.run_last);
                    errors++;
                end
                if (out_data.out_list_end !== head.out_list_end)
                begin
                    $error("out_list_end: expected %0b, actual %0b",
                           head.out_list_end, out_data.out_list_end);
                    errors++;
                end
            end
        end
    end

    // count cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        size_reg_model = GS_RESET;
        group_fill     = 0;
        items_sent     = 0;
        idle_en        = 1'b1;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_size();
        test_pass_through();
        test_full_group_max();
        test_size_lowered();
        test_switch_to_pass_through();
        test_random_lists(items_sent + 120);
        test_no_idle_stretch();
        test_output_backpressure();
        test_random_lists(items_sent + 140);

        // drain and give the block time to show any stray result
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
